@@ rtl/abh_pkg.sv @@
// Shared definitions for the ARX block hash: chain IV, round constants,
// shared-unit opcodes, the sequencer control bundle and the rotate helper.
// No dependencies.
`timescale 1ns / 1ps

package abh_pkg;

  // Round count default and index width (covers up to 16 rounds)
  localparam int unsigned ROUND_COUNT_DEF = 8;
  localparam int unsigned RIDX_W          = 4;

  localparam logic [31:0] XOR_CONST = 32'hA5A5A5A5;
  localparam logic [31:0] ADD_CONST = 32'h3C3C3C3C;
  localparam logic [10:0] LANE_MUL  = 11'd73;
  localparam logic [10:0] RND_MUL   = 11'd91;
  localparam logic [4:0]  MIX_OFS   = 5'd13;
  localparam logic [4:0]  MIX_MUL   = 5'd7;
  localparam logic [7:0]  PAD_BYTE  = 8'h80;

  localparam logic [31:0] INIT_WORDS [16] = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
    32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
    32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
    32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917
  };

  // Operations of the shared word unit
  typedef enum logic [1:0] {
    OP_KEY = 2'd0,  // derive subkey, add it to the head word
    OP_RND = 2'd1,  // finish the round function on the head word
    OP_MIX = 2'd2,  // xor in rotated word three places ahead
    OP_FF  = 2'd3   // feed-forward with block word and prior chain word
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              step;    // shift the chain ring, write unit result
    logic              key_ld;  // capture subkey and partial sum
    logic              done;    // last step of a compression
    logic [RIDX_W-1:0] rnd;
    logic [3:0]        idx;     // chain word being worked on
  } ctrl_t;

  // Rotate left; a zero amount passes the word through
  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} << s;
    return d[63:32];
  endfunction

endpackage

@@ rtl/abh_alu.sv @@
// Shared word unit of the ARX block hash: subkey derivation, round
// function, sequential mix and feed-forward on one 32-bit word.
// Depends on abh_pkg.
`timescale 1ns / 1ps

module abh_alu (
  input  abh_pkg::ctrl_t ctrl,
  input  logic [31:0]    head,     // chain word under work
  input  logic [31:0]    tap,      // chain word three places ahead
  input  logic [31:0]    base,     // selected block word
  input  logic [31:0]    prior,    // chain word from before the compression
  input  logic [31:0]    key_q,    // captured subkey
  input  logic [31:0]    acc_q,    // captured head + subkey
  output logic [31:0]    key,
  output logic [31:0]    sum,
  output logic [31:0]    result
);
  import abh_pkg::*;

  logic [2:0]  lane;
  logic [10:0] kconst;
  logic [31:0] t0;
  logic [31:0] t1;
  logic [31:0] rnd_word;
  logic [31:0] mix_word;
  logic [31:0] ff_word;
  logic [4:0]  rnd5;
  logic [4:0]  mix_sh;

  assign lane = ctrl.idx[2:0];
  assign rnd5 = 5'(ctrl.rnd);

  // Subkey from the block word and its partial sum with the head word
  assign kconst = 11'(lane) * LANE_MUL + 11'(ctrl.rnd) * RND_MUL;
  assign key    = rotl(base ^ {21'b0, kconst}, rnd5 + 5'(lane));
  assign sum    = head + key;

  // Rest of the round: rotations by 7 and r+3 fold into one by r+10
  assign t0       = (acc_q ^ XOR_CONST) + ADD_CONST;
  assign t1       = rotl(t0, rnd5 + 5'd10) ^ key_q;
  assign rnd_word = rotl(t1, rnd5 + 5'd5);

  // In-place mix and feed-forward
  assign mix_sh   = 5'(ctrl.idx) * MIX_MUL + MIX_OFS;
  assign mix_word = head ^ rotl(tap, mix_sh);
  assign ff_word  = head ^ base ^ prior;

  // Select the word to write back
  always_comb begin
    case (ctrl.op)
      OP_RND:  result = rnd_word;
      OP_MIX:  result = mix_word;
      OP_FF:   result = ff_word;
      default: result = head;
    endcase
  end

endmodule

@@ rtl/abh_seq.sv @@
// Compression sequencer of the ARX block hash: steps rounds and words
// and drives the shared word unit through its control bundle.
// Depends on abh_pkg.
`timescale 1ns / 1ps

module abh_seq #(
  parameter int unsigned ROUND_COUNT = abh_pkg::ROUND_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output abh_pkg::ctrl_t ctrl
);
  import abh_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_UPD  = 4'b0010,
    PH_MIX  = 4'b0100,
    PH_FF   = 4'b1000
  } phase_t;

  localparam logic [RIDX_W-1:0] LAST_RND = RIDX_W'(ROUND_COUNT - 1);

  phase_t            phase_r, phase_nxt;
  logic [RIDX_W-1:0] rnd_r, rnd_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              sub_r, sub_nxt;

  // Step through word updates (subkey step, then round step), mix, then feed-forward
  always_comb begin
    phase_nxt   = phase_r;
    rnd_nxt     = rnd_r;
    idx_nxt     = idx_r;
    sub_nxt     = sub_r;
    ctrl.op     = OP_KEY;
    ctrl.step   = 1'b0;
    ctrl.key_ld = 1'b0;
    ctrl.done   = 1'b0;
    ctrl.rnd    = rnd_r;
    ctrl.idx    = idx_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_UPD;
          rnd_nxt   = '0;
          idx_nxt   = '0;
          sub_nxt   = 1'b0;
        end
      end
      PH_UPD: begin
        if (!sub_r) begin
          ctrl.key_ld = 1'b1;
          sub_nxt     = 1'b1;
        end else begin
          ctrl.op   = OP_RND;
          ctrl.step = 1'b1;
          sub_nxt   = 1'b0;
          idx_nxt   = idx_r + 4'd1;
          if (idx_r == 4'd15) phase_nxt = PH_MIX;
        end
      end
      PH_MIX: begin
        ctrl.op   = OP_MIX;
        ctrl.step = 1'b1;
        idx_nxt   = idx_r + 4'd1;
        if (idx_r == 4'd15) begin
          if (rnd_r == LAST_RND) begin
            phase_nxt = PH_FF;
          end else begin
            phase_nxt = PH_UPD;
            rnd_nxt   = rnd_r + RIDX_W'(1);
          end
        end
      end
      PH_FF: begin
        ctrl.op   = OP_FF;
        ctrl.step = 1'b1;
        idx_nxt   = idx_r + 4'd1;
        if (idx_r == 4'd15) begin
          phase_nxt = PH_IDLE;
          ctrl.done = 1'b1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
      sub_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      sub_r   <= sub_nxt;
    end
  end

endmodule

@@ rtl/arx_block_hash_256.sv @@
// ARX block hash, 256-bit digest. Bytes are taken only while idle; the one that
// fills a 32-byte block starts a compression (a subkey and a round step per word
// update, one step per mix and feed-forward word, on one shared word unit).
// An end request adds a padding step and a compression, plus a length step and a
// second compression when the length does not fit, then four digest words, one per
// cycle unless stalled. Synchronous active-low reset loads the chain, clears counts.
`timescale 1ns / 1ps

module arx_block_hash_256 #(
  parameter int unsigned ROUND_COUNT = abh_pkg::ROUND_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] digest_word
  output logic        out_tlast   // digest_last
);
  import abh_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_COMP = 5'b00010,
    ST_PAD  = 5'b00100,
    ST_LEN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  state_t      after_r, after_nxt;
  logic [31:0] chain_r [16];
  logic [31:0] prior_r [16];
  logic [31:0] blk_r   [8];
  logic [60:0] count_r;
  logic [4:0]  fill_r;
  logic [1:0]  k_r;
  logic [31:0] key_r;
  logic [31:0] acc_r;
  logic        start;
  logic        in_acc;
  logic        out_acc;
  logic        out_done;
  logic [63:0] bit_len;
  logic [2:0]  blk_addr;
  logic [31:0] alu_key;
  logic [31:0] alu_sum;
  logic [31:0] alu_res;
  ctrl_t       ctrl;

  assign in_acc   = in_tvalid & in_tready;
  assign out_acc  = out_tvalid & out_tready;
  assign out_done = out_acc & (k_r == 2'd3);
  assign bit_len  = {count_r, 3'b000};

  // Top-level flow: absorb, pad, length block, emit
  always_comb begin
    state_nxt = state_r;
    after_nxt = after_r;
    start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser && fill_r == 5'd31) begin
            start     = 1'b1;
            state_nxt = ST_COMP;
            after_nxt = in_tlast ? ST_PAD : ST_IDLE;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        start     = 1'b1;
        state_nxt = ST_COMP;
        after_nxt = (fill_r[4] & fill_r[3]) ? ST_LEN : ST_OUT;
      end
      ST_LEN: begin
        start     = 1'b1;
        state_nxt = ST_COMP;
        after_nxt = ST_OUT;
      end
      ST_COMP: begin
        if (ctrl.done) state_nxt = after_r;
      end
      ST_OUT: begin
        if (out_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers: state, byte count, block fill, digest word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      after_r <= ST_IDLE;
      count_r <= '0;
      fill_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      if (in_acc && in_tuser) begin
        count_r <= count_r + 61'd1;
        fill_r  <= fill_r + 5'd1;
      end
      if (out_acc) k_r <= k_r + 2'd1;
      if (out_done) begin
        count_r <= '0;
        fill_r  <= '0;
      end
    end
  end

  // Block words: pack bytes, pad, and place the bit length
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc && in_tuser) begin
      if (fill_r[1:0] == 2'd0) blk_r[fill_r[4:2]] <= {24'b0, in_tdata};
      else blk_r[fill_r[4:2]][8*fill_r[1:0] +: 8] <= in_tdata;
    end
    if (state_r == ST_PAD) begin
      if (fill_r[1:0] == 2'd0) blk_r[fill_r[4:2]] <= {24'b0, PAD_BYTE};
      else blk_r[fill_r[4:2]][8*fill_r[1:0] +: 8] <= PAD_BYTE;
      for (int i = 0; i < 8; i++) begin
        if (3'(i) > fill_r[4:2]) blk_r[i] <= '0;
      end
      if (!(fill_r[4] & fill_r[3])) begin
        blk_r[6] <= bit_len[31:0];
        blk_r[7] <= bit_len[63:32];
      end
    end
    if (state_r == ST_LEN) begin
      for (int i = 0; i < 6; i++) blk_r[i] <= '0;
      blk_r[6] <= bit_len[31:0];
      blk_r[7] <= bit_len[63:32];
    end
  end

  // Chain ring: head is the word under work, shift one place per step
  always_ff @(posedge clk) begin
    if (!rst_n || out_done) begin
      for (int i = 0; i < 16; i++) chain_r[i] <= INIT_WORDS[i];
    end else if (ctrl.step) begin
      for (int i = 0; i < 15; i++) chain_r[i] <= chain_r[i+1];
      chain_r[15] <= alu_res;
    end
  end

  // Prior chain snapshot, rotated along during feed-forward
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) prior_r[i] <= chain_r[i];
    end else if (ctrl.step && ctrl.op == OP_FF) begin
      for (int i = 0; i < 15; i++) prior_r[i] <= prior_r[i+1];
      prior_r[15] <= prior_r[0];
    end
  end

  // Hold subkey and partial sum from the subkey step for the round step
  always_ff @(posedge clk) begin
    if (ctrl.key_ld) begin
      key_r <= alu_key;
      acc_r <= alu_sum;
    end
  end

  // Block word select: rotated by round for subkeys, plain for feed-forward
  assign blk_addr = (ctrl.op == OP_FF) ? ctrl.idx[2:0]
                                       : ctrl.idx[2:0] + 3'(ctrl.rnd);

  abh_seq #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ctrl  (ctrl)
  );

  abh_alu u_alu (
    .ctrl   (ctrl),
    .head   (chain_r[0]),
    .tap    (chain_r[3]),
    .base   (blk_r[blk_addr]),
    .prior  (prior_r[0]),
    .key_q  (key_r),
    .acc_q  (acc_r),
    .key    (alu_key),
    .sum    (alu_sum),
    .result (alu_res)
  );

  // Handshake and digest words
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {chain_r[{1'b0, k_r, 1'b1}], chain_r[{1'b0, k_r, 1'b0}]};
  assign out_tlast  = (k_r == 2'd3);

endmodule

@@ rtl/abh_checker.sv @@
// Port-level checks for the ARX block hash and the bind that attaches them.
// Depends on arx_block_hash_256 (bind target only).
`timescale 1ns / 1ps

module abh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // No new request is taken while digest words are pending
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while digest is pending");

  // A stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("digest word changed under stall");

  // Digest words follow one another without a gap until the last
  a_out_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside digest burst");

  // The last digest word ends the burst
  a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("digest word after last");

  // An end request always makes the block busy
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("ready right after end request");

endmodule

bind arx_block_hash_256 abh_checker u_abh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
